@@ hw/rtl/srtp_ri_pkg.sv @@
// Shared types and constants for the SRTP rollover index and IV block.
package srtp_ri_pkg;

   localparam int unsigned HEADER_BYTES = 12;
   localparam int unsigned CSR_INDEX_W  = 2;
   localparam int unsigned CSR_DATA_W   = 64;
   localparam int unsigned SEQ_W        = 16;
   localparam int unsigned SRC_W        = 32;
   localparam int unsigned LEN_W        = 16;
   localparam int unsigned ROC_W        = 32;
   localparam int unsigned INDEX_W      = 48;
   localparam int unsigned SALT_UPPER_W = 48;
   localparam int unsigned SALT_LOWER_W = 64;
   localparam int unsigned SLOT_W       = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SALT_UPPER = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SALT_LOWER = 2'd2;

   typedef struct packed {
      logic capture;
      logic skip;
      logic scan_check;
      logic scan_next;
      logic pick_hit;
      logic pick_miss;
      logic load;
      logic update;
   } ctrl_cmd_type;

   typedef struct packed {
      logic bypass;
      logic hit;
      logic scan_last;
   } ctrl_status_type;

endpackage

@@ hw/rtl/srtp_ri_ctrl.sv @@
// Sequencer for the table walk, entry load and result update.
module srtp_ri_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  srtp_ri_pkg::ctrl_status_type status,
   output srtp_ri_pkg::ctrl_cmd_type    cmd
);
   import srtp_ri_pkg::*;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SKIP    = 3'd1;
   localparam logic [2:0] S_SCAN_RD = 3'd2;
   localparam logic [2:0] S_SCAN_CK = 3'd3;
   localparam logic [2:0] S_LOAD_RD = 3'd4;
   localparam logic [2:0] S_UPDATE  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = status.bypass ? S_SKIP : S_SCAN_RD;
            end
         end
         S_SKIP: begin
            cmd.skip = 1'b1;
            state_in = S_IDLE;
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CK;
         end
         S_SCAN_CK: begin
            cmd.scan_check = 1'b1;
            if (status.hit) begin
               cmd.pick_hit = 1'b1;
               state_in     = S_LOAD_RD;
            end else if (status.scan_last) begin
               cmd.pick_miss = 1'b1;
               state_in      = S_LOAD_RD;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = S_SCAN_RD;
            end
         end
         S_LOAD_RD: begin
            cmd.load = 1'b1;
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

@@ hw/rtl/srtp_ri_dp.sv @@
// Datapath: config registers, rollover table memory, index and IV forming.
module srtp_ri_dp #(
   parameter int unsigned TABLE_ENTRIES = 8
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          csr_write_enable,
   input  logic [srtp_ri_pkg::CSR_INDEX_W-1:0]           csr_index,
   input  logic [srtp_ri_pkg::CSR_DATA_W-1:0]            csr_write_data,
   input  logic [srtp_ri_pkg::SEQ_W-1:0]                 req_sequence_number,
   input  logic [srtp_ri_pkg::SRC_W-1:0]                 req_stream_id,
   input  logic [srtp_ri_pkg::LEN_W-1:0]                 req_packet_length,
   input  srtp_ri_pkg::ctrl_cmd_type                     cmd,
   output srtp_ri_pkg::ctrl_status_type                  status,
   output logic                                          rsp_valid,
   output logic                                          rsp_processed,
   output logic [srtp_ri_pkg::ROC_W-1:0]                 rsp_rollover_count,
   output logic [srtp_ri_pkg::INDEX_W-1:0]               rsp_packet_index,
   output logic [srtp_ri_pkg::SALT_UPPER_W-1:0]          rsp_iv_upper,
   output logic signed [srtp_ri_pkg::SALT_LOWER_W-1:0]   rsp_iv_lower,
   output logic [srtp_ri_pkg::SLOT_W-1:0]                rsp_table_slot,
   output logic                                          rsp_table_full_fallback
);
   import srtp_ri_pkg::*;

   localparam int unsigned IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int unsigned WORD_W = SRC_W + ROC_W + SEQ_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   // config
   logic                    enable_ff;
   logic [SALT_UPPER_W-1:0] salt_upper_ff;
   logic [SALT_LOWER_W-1:0] salt_lower_ff;

   // table
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [WORD_W-1:0]        mem [TABLE_ENTRIES];
   logic [WORD_W-1:0]        rd_word_ff;
   logic [IDX_W-1:0]         rd_addr;

   // item
   logic [SEQ_W-1:0] seq_ff;
   logic [SRC_W-1:0] src_ff;
   logic [IDX_W-1:0] scan_idx_ff;
   logic             free_found_ff;
   logic [IDX_W-1:0] free_idx_ff;
   logic [IDX_W-1:0] slot_ff;
   logic             fallback_ff;

   // results
   logic                    rsp_valid_ff;
   logic                    rsp_processed_ff;
   logic [ROC_W-1:0]        rsp_roc_ff;
   logic [INDEX_W-1:0]      rsp_index_ff;
   logic [SALT_UPPER_W-1:0] rsp_iv_upper_ff;
   logic [SALT_LOWER_W-1:0] rsp_iv_lower_ff;
   logic [SLOT_W-1:0]       rsp_slot_ff;
   logic                    rsp_fallback_ff;

   logic [SRC_W-1:0]   rd_src;
   logic [ROC_W-1:0]   rd_roc;
   logic [SEQ_W-1:0]   rd_last;
   logic               scan_valid;
   logic               slot_valid;
   logic [SRC_W-1:0]   base_src;
   logic [ROC_W-1:0]   base_roc;
   logic [SEQ_W-1:0]   base_last;
   logic [ROC_W-1:0]   roc_new;
   logic [INDEX_W-1:0] index_new;
   logic [IDX_W+SLOT_W-1:0] slot_ext;

   assign rd_src  = rd_word_ff[WORD_W-1 -: SRC_W];
   assign rd_roc  = rd_word_ff[SEQ_W +: ROC_W];
   assign rd_last = rd_word_ff[SEQ_W-1:0];

   assign scan_valid = valid_ff[scan_idx_ff];
   assign slot_valid = valid_ff[slot_ff];

   assign status.bypass    = !enable_ff ||
                             (req_packet_length < LEN_W'(HEADER_BYTES));
   assign status.hit       = scan_valid && (rd_src == src_ff);
   assign status.scan_last = (scan_idx_ff == LAST_IDX);

   assign rd_addr = cmd.load ? slot_ff : scan_idx_ff;

   // a never-claimed entry reads as zero rollover and last sequence, with the packet's own source
   assign base_src  = slot_valid ? rd_src  : src_ff;
   assign base_roc  = slot_valid ? rd_roc  : '0;
   assign base_last = slot_valid ? rd_last : '0;
   assign roc_new   = (seq_ff < base_last) ? base_roc + ROC_W'(1) : base_roc;
   assign index_new = {roc_new, seq_ff};
   assign slot_ext  = {{SLOT_W{1'b0}}, slot_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         salt_upper_ff <= '0;
         salt_lower_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ENABLE:     enable_ff     <= csr_write_data[0];
            CSR_SALT_UPPER: salt_upper_ff <= csr_write_data[SALT_UPPER_W-1:0];
            CSR_SALT_LOWER: salt_lower_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (csr_write_enable && (csr_index == CSR_SALT_LOWER)) begin
         valid_ff <= '0;
      end else if (cmd.update) begin
         valid_ff[slot_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         mem[slot_ff] <= {base_src, roc_new, seq_ff};
      end
      rd_word_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         seq_ff        <= req_sequence_number;
         src_ff        <= req_stream_id;
         scan_idx_ff   <= '0;
         free_found_ff <= 1'b0;
      end else begin
         if (cmd.scan_next) begin
            scan_idx_ff <= scan_idx_ff + IDX_W'(1);
         end
         if (cmd.scan_check && !free_found_ff && !scan_valid) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= scan_idx_ff;
         end
      end
      if (cmd.pick_hit) begin
         slot_ff     <= scan_idx_ff;
         fallback_ff <= 1'b0;
      end else if (cmd.pick_miss) begin
         if (free_found_ff) begin
            slot_ff     <= free_idx_ff;
            fallback_ff <= 1'b0;
         end else if (!scan_valid) begin
            slot_ff     <= scan_idx_ff;
            fallback_ff <= 1'b0;
         end else begin
            slot_ff     <= '0;
            fallback_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.skip || cmd.update;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.skip) begin
         rsp_processed_ff <= 1'b0;
         rsp_roc_ff       <= '0;
         rsp_index_ff     <= '0;
         rsp_iv_upper_ff  <= '0;
         rsp_iv_lower_ff  <= '0;
         rsp_slot_ff      <= '0;
         rsp_fallback_ff  <= 1'b0;
      end else if (cmd.update) begin
         rsp_processed_ff <= 1'b1;
         rsp_roc_ff       <= roc_new;
         rsp_index_ff     <= index_new;
         rsp_iv_upper_ff  <= salt_upper_ff ^ SALT_UPPER_W'(src_ff[SRC_W-1:16]);
         rsp_iv_lower_ff  <= salt_lower_ff ^ {src_ff[15:0], index_new};
         rsp_slot_ff      <= slot_ext[SLOT_W-1:0];
         rsp_fallback_ff  <= fallback_ff;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_processed           = rsp_processed_ff;
   assign rsp_rollover_count      = rsp_roc_ff;
   assign rsp_packet_index        = rsp_index_ff;
   assign rsp_iv_upper            = rsp_iv_upper_ff;
   assign rsp_iv_lower            = rsp_iv_lower_ff;
   assign rsp_table_slot          = rsp_slot_ff;
   assign rsp_table_full_fallback = rsp_fallback_ff;

   a_word_single_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result word strobe held two cycles");

   a_fallback_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full_fallback |-> rsp_table_slot == '0)
      else $error("fallback word not on entry zero");

   a_index_low_is_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_processed |-> rsp_packet_index[SEQ_W-1:0] == seq_ff)
      else $error("packet index low half differs from sequence number");

   a_unprocessed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_processed |-> rsp_rollover_count == '0 &&
         rsp_packet_index == '0 && !rsp_table_full_fallback)
      else $error("unprocessed word carries data");

endmodule

@@ hw/rtl/srtp_rollover_index_iv_top.sv @@
// Top level of the SRTP rollover counter, packet index and AES-CM IV block.
// A packet word is taken when start is high and busy is low. A disabled or
// short packet gives its result word after a skip state. Otherwise
// the block walks the rollover table one entry at a time, through a read
// and a check state, until the source matches or the table ends, then
// reads the chosen entry once more in a load state and writes the result in
// an update state. busy falls in the cycle the result shows.
// rsp_valid marks each result word for exactly one cycle and cannot be held
// off; the receiver must take it then. Writing salt_lower empties the table.
module srtp_rollover_index_iv_top #(
   parameter int unsigned TABLE_ENTRIES = 8
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          csr_write_enable,
   input  logic [srtp_ri_pkg::CSR_INDEX_W-1:0]           csr_index,
   input  logic [srtp_ri_pkg::CSR_DATA_W-1:0]            csr_write_data,
   input  logic                                          start,
   output logic                                          busy,
   input  logic [srtp_ri_pkg::SEQ_W-1:0]                 req_sequence_number,
   input  logic [srtp_ri_pkg::SRC_W-1:0]                 req_stream_id,
   input  logic [srtp_ri_pkg::LEN_W-1:0]                 req_packet_length,
   output logic                                          rsp_valid,
   output logic                                          rsp_processed,
   output logic [srtp_ri_pkg::ROC_W-1:0]                 rsp_rollover_count,
   output logic [srtp_ri_pkg::INDEX_W-1:0]               rsp_packet_index,
   output logic [srtp_ri_pkg::SALT_UPPER_W-1:0]          rsp_iv_upper,
   output logic signed [srtp_ri_pkg::SALT_LOWER_W-1:0]   rsp_iv_lower,
   output logic [srtp_ri_pkg::SLOT_W-1:0]                rsp_table_slot,
   output logic                                          rsp_table_full_fallback
);
   import srtp_ri_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   srtp_ri_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   srtp_ri_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .csr_write_enable        (csr_write_enable),
      .csr_index               (csr_index),
      .csr_write_data          (csr_write_data),
      .req_sequence_number     (req_sequence_number),
      .req_stream_id           (req_stream_id),
      .req_packet_length       (req_packet_length),
      .cmd                     (cmd),
      .status                  (status),
      .rsp_valid               (rsp_valid),
      .rsp_processed           (rsp_processed),
      .rsp_rollover_count      (rsp_rollover_count),
      .rsp_packet_index        (rsp_packet_index),
      .rsp_iv_upper            (rsp_iv_upper),
      .rsp_iv_lower            (rsp_iv_lower),
      .rsp_table_slot          (rsp_table_slot),
      .rsp_table_full_fallback (rsp_table_full_fallback)
   );

endmodule

@@ dv/srtp_rollover_index_iv_top_test.sv @@
// Self-checking testbench for the SRTP rollover index and AES-CM IV block.
module srtp_rollover_index_iv_top_test;
   import srtp_ri_pkg::*;

   localparam int unsigned TABLE_ENTRIES = 8;
   localparam int unsigned RANDOM_ITEMS  = 1950;
   localparam int unsigned CYCLE_LIMIT   = 1000000;
   localparam int unsigned POOL_MAX      = 12;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [SEQ_W-1:0] seq;
      logic [SRC_W-1:0] ssrc;
      logic [LEN_W-1:0] len;
   } packet_type;

   typedef struct packed {
      logic                    processed;
      logic [ROC_W-1:0]        roc;
      logic [INDEX_W-1:0]      index;
      logic [SALT_UPPER_W-1:0] iv_upper;
      logic [SALT_LOWER_W-1:0] iv_lower;
      logic [SLOT_W-1:0]       slot;
      logic                    fallback;
   } index_word_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_write_data = '0;
   logic                    start = 1'b0;
   logic                    busy;
   logic [SEQ_W-1:0]        req_sequence_number = '0;
   logic [SRC_W-1:0]        req_stream_id = '0;
   logic [LEN_W-1:0]        req_packet_length = '0;
   logic                    rsp_valid;
   logic                    rsp_processed;
   logic [ROC_W-1:0]        rsp_rollover_count;
   logic [INDEX_W-1:0]      rsp_packet_index;
   logic [SALT_UPPER_W-1:0] rsp_iv_upper;
   logic signed [SALT_LOWER_W-1:0] rsp_iv_lower;
   logic [SLOT_W-1:0]       rsp_table_slot;
   logic                    rsp_table_full_fallback;

   // predictor copy of registers and rollover table
   logic                    ri_enable;
   logic [SALT_UPPER_W-1:0] ri_salt_upper;
   logic [SALT_LOWER_W-1:0] ri_salt_lower;
   logic                    tab_valid [TABLE_ENTRIES];
   logic [SRC_W-1:0]        tab_src   [TABLE_ENTRIES];
   logic [ROC_W-1:0]        tab_roc   [TABLE_ENTRIES];
   logic [SEQ_W-1:0]        tab_last  [TABLE_ENTRIES];

   packet_type     pending_packets [$];
   index_word_type expected_index_words [$];
   packet_type     driven_packet;
   index_word_type want;
   int unsigned send_gap = 0;
   int unsigned calm_left = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   srtp_rollover_index_iv_top #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) i_dut (
      .clock                   (clock),
      .reset                   (reset),
      .csr_write_enable        (csr_write_enable),
      .csr_index               (csr_index),
      .csr_write_data          (csr_write_data),
      .start                   (start),
      .busy                    (busy),
      .req_sequence_number     (req_sequence_number),
      .req_stream_id           (req_stream_id),
      .req_packet_length       (req_packet_length),
      .rsp_valid               (rsp_valid),
      .rsp_processed           (rsp_processed),
      .rsp_rollover_count      (rsp_rollover_count),
      .rsp_packet_index        (rsp_packet_index),
      .rsp_iv_upper            (rsp_iv_upper),
      .rsp_iv_lower            (rsp_iv_lower),
      .rsp_table_slot          (rsp_table_slot),
      .rsp_table_full_fallback (rsp_table_full_fallback)
   );

   always #6 clock = ~clock;

   function automatic void clear_rollover_table();
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
         tab_valid[k] = 1'b0;
         tab_src[k]   = '0;
         tab_roc[k]   = '0;
         tab_last[k]  = '0;
      end
   endfunction

   function automatic index_word_type predict_index_iv(packet_type p);
      index_word_type w;
      int unsigned slot;
      logic hit;
      logic [INDEX_W-1:0] idx;
      w = '0;
      if (!ri_enable || p.len < LEN_W'(HEADER_BYTES))
         return w;
      slot = 0;
      hit  = 1'b0;
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
         if (!hit && tab_valid[k] && tab_src[k] == p.ssrc) begin
            slot = k;
            hit  = 1'b1;
         end
      end
      if (!hit) begin
         for (int k = 0; k < TABLE_ENTRIES; k++) begin
            if (!hit && !tab_valid[k]) begin
               slot         = k;
               hit          = 1'b1;
               tab_valid[k] = 1'b1;
               tab_src[k]   = p.ssrc;
               tab_roc[k]   = '0;
               tab_last[k]  = '0;
            end
         end
         // table full: entry 0 reused, keeps its source id
         if (!hit)
            w.fallback = 1'b1;
      end
      if (p.seq < tab_last[slot])
         tab_roc[slot] = tab_roc[slot] + ROC_W'(1);
      tab_last[slot] = p.seq;
      idx = {tab_roc[slot], p.seq};
      w.processed = 1'b1;
      w.roc       = tab_roc[slot];
      w.index     = idx;
      w.iv_upper  = ri_salt_upper ^ {16'h0000, p.ssrc[31:16]};
      w.iv_lower  = ri_salt_lower ^ {p.ssrc[15:0], idx};
      w.slot      = slot[SLOT_W-1:0];
      return w;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
      if (mismatch_count < 100)
         $display("mismatch %s: got %h expected %h", what, got, exp_val);
      mismatch_count++;
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         CSR_ENABLE: begin
            ri_enable = data[0];
         end
         CSR_SALT_UPPER: begin
            ri_salt_upper = data[SALT_UPPER_W-1:0];
         end
         CSR_SALT_LOWER: begin
            ri_salt_lower = data;
            clear_rollover_table();
         end
         default: begin
         end
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic queue_packet(logic [SEQ_W-1:0] seq, logic [SRC_W-1:0] ssrc,
                               logic [LEN_W-1:0] len);
      packet_type p;
      p.seq  = seq;
      p.ssrc = ssrc;
      p.len  = len;
      pending_packets.push_back(p);
   endtask

   task automatic wait_idle();
      do
         @(negedge clock);
      while (pending_packets.size() != 0 || start || expected_index_words.size() != 0);
   endtask

   function automatic logic [63:0] pick_value();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            expected_index_words.push_back(predict_index_iv(driven_packet));
         if (!start || !busy) begin
            if (send_gap > 0) begin
               send_gap--;
               start               <= 1'b0;
               req_sequence_number <= SEQ_W'($urandom);
               req_stream_id       <= $urandom;
               req_packet_length   <= LEN_W'($urandom);
            end else if (pending_packets.size() != 0) begin
               driven_packet        = pending_packets.pop_front();
               start               <= 1'b1;
               req_sequence_number <= driven_packet.seq;
               req_stream_id       <= driven_packet.ssrc;
               req_packet_length   <= driven_packet.len;
               if (calm_left > 0) begin
                  calm_left--;
                  send_gap = 0;
               end else if ($urandom_range(0, 29) == 0) begin
                  calm_left = $urandom_range(10, 40);
                  send_gap  = 0;
               end else begin
                  send_gap = $urandom_range(0, 19);
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_index_words.size() == 0) begin
            report_mismatch("word with none expected", 64'(rsp_packet_index), '0);
         end else begin
            want = expected_index_words.pop_front();
            if (rsp_processed !== want.processed)
               report_mismatch("processed", 64'(rsp_processed), 64'(want.processed));
            if (rsp_rollover_count !== want.roc)
               report_mismatch("rollover_count", 64'(rsp_rollover_count), 64'(want.roc));
            if (rsp_packet_index !== want.index)
               report_mismatch("packet_index", 64'(rsp_packet_index), 64'(want.index));
            if (rsp_iv_upper !== want.iv_upper)
               report_mismatch("iv_upper", 64'(rsp_iv_upper), 64'(want.iv_upper));
            if (rsp_iv_lower !== want.iv_lower)
               report_mismatch("iv_lower", rsp_iv_lower, want.iv_lower);
            if (rsp_table_slot !== want.slot)
               report_mismatch("table_slot", 64'(rsp_table_slot), 64'(want.slot));
            if (rsp_table_full_fallback !== want.fallback)
               report_mismatch("table_full_fallback", 64'(rsp_table_full_fallback),
                               64'(want.fallback));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      logic [SRC_W-1:0] pool_src [POOL_MAX];
      logic [SEQ_W-1:0] pool_seq [POOL_MAX];
      logic [SEQ_W-1:0] seq;
      int unsigned random_sent;
      int unsigned pool_size;
      int unsigned burst;
      int unsigned s;
      logic [LEN_W-1:0] len;

      ri_enable     = 1'b0;
      ri_salt_upper = '0;
      ri_salt_lower = '0;
      clear_rollover_table();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // disabled after reset
      queue_packet(16'h1234, 32'h0000_0000, 16'd100);
      queue_packet(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
      wait_idle();

      write_csr(CSR_ENABLE, 64'h1);
      write_csr(CSR_SALT_UPPER, '1);
      write_csr(CSR_SALT_LOWER, '1);
      queue_packet(16'h0000, 32'h0000_0000, 16'd11);
      queue_packet(16'h0005, 32'h0000_0000, 16'd0);
      queue_packet(16'h0000, 32'h0000_0000, 16'd12);
      queue_packet(16'hFFFF, 32'h0000_0000, 16'hFFFF);
      queue_packet(16'h0003, 32'h0000_0000, 16'd12);
      // fill the remaining entries
      queue_packet(16'h0100, 32'hFFFF_FFFF, 16'd60);
      for (int k = 1; k < TABLE_ENTRIES - 1; k++)
         queue_packet(16'(k * 1000), 32'(k * 32'h0101_0101), 16'd60);
      // table full: fallback on entry 0, then a drop that rolls entry 0
      queue_packet(16'h000A, 32'hA5A5_5A5A, 16'd40);
      queue_packet(16'h0002, 32'h5A5A_A5A5, 16'd40);
      queue_packet(16'h0007, 32'h0000_0000, 16'd40);
      wait_idle();

      // salt_upper write keeps the table
      write_csr(CSR_SALT_UPPER, 64'h0);
      queue_packet(16'h0001, 32'hFFFF_FFFF, 16'd20);
      wait_idle();
      write_csr(CSR_ENABLE, 64'hFFFF_FFFF_FFFF_FFFE);
      queue_packet(16'h0000, 32'hFFFF_FFFF, 16'd20);
      wait_idle();
      write_csr(CSR_ENABLE, '1);
      queue_packet(16'h0000, 32'hFFFF_FFFF, 16'd20);
      wait_idle();
      write_csr(CSR_SALT_LOWER, 64'h0);
      queue_packet(16'h8000, 32'hFFFF_FFFF, 16'd13);
      queue_packet(16'h7FFF, 32'h8000_0001, 16'd12);
      wait_idle();

      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 1) == 0)
            write_csr(CSR_ENABLE, ($urandom_range(0, 7) == 0) ?
                      {$urandom, $urandom} & ~64'h1 : {$urandom, $urandom} | 64'h1);
         if ($urandom_range(0, 1) == 0)
            write_csr(CSR_SALT_UPPER, pick_value());
         if ($urandom_range(0, 1) == 0)
            write_csr(CSR_SALT_LOWER, pick_value());
         if ($urandom_range(0, 15) == 0)
            write_csr(CSR_UNUSED, pick_value());

         pool_size = $urandom_range(1, POOL_MAX);
         for (int k = 0; k < POOL_MAX; k++) begin
            case ($urandom_range(0, 9))
               0: pool_src[k] = '0;
               1: pool_src[k] = '1;
               default: pool_src[k] = $urandom;
            endcase
            pool_seq[k] = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(65000, 65535))
                                                      : 16'($urandom);
         end

         burst = $urandom_range(20, 150);
         for (int n = 0; n < burst; n++) begin
            s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, pool_size - 1)
                                            : $urandom_range(0, (pool_size + 1) / 2 - 1);
            case ($urandom_range(0, 31))
               0: seq = SEQ_W'($urandom);
               1, 2: seq = pool_seq[s] - 16'($urandom_range(1, 50));
               3: seq = pool_seq[s];
               default: seq = pool_seq[s] + 16'($urandom_range(1, 40));
            endcase
            pool_seq[s] = seq;
            case ($urandom_range(0, 9))
               0: len = 16'($urandom_range(0, HEADER_BYTES - 1));
               1: len = 16'(HEADER_BYTES);
               2: len = '1;
               default: len = 16'($urandom_range(HEADER_BYTES, 65535));
            endcase
            queue_packet(seq, pool_src[s], len);
            random_sent++;
         end
         wait_idle();
      end

      wait_idle();
      repeat (2 * TABLE_ENTRIES + 5) @(posedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
